### rtl/core/lfq_pkg.sv
// Shared constants and types for the linked FIFO with per-thread free lists.
`timescale 1ns / 1ps

package lfq_pkg;

  localparam int POOL_NODES_DEF = 1024;
  localparam int THREADS_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // free list update for one thread
  typedef struct packed {
    logic pop;
    logic push;
  } fl_cmd_t;

endpackage

### rtl/core/linked_fifo_with_thread_free_lists_core.sv
// Top level: linked FIFO over a node pool with per-thread free lists.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: in_mode
//   selects enqueue or dequeue, in_thread_id picks the caller's free list,
//   in_data_in is the value to enqueue. Output channel (out_valid/out_ready)
//   returns one result beat per request: ok, dequeued value, recycled flag
//   and the caller's free list size after the operation.
//   A request issues one read of the node memory in the accept cycle (free
//   list successor or head node); the execute state uses the registered
//   read data and writes the node memory back. A new request is accepted
//   only in the idle state, after the previous one has completed, and the
//   result is loaded into the output register when execute completes.
//   A node's word holds the link to its successor and the successor's value,
//   so a dequeue needs only one read. The queue is empty when head == tail.
//   Reset leaves an empty queue with node 0 as dummy and all free lists
//   empty; node memory needs no clearing. If out_ready is low, the finished
//   result holds in the output register and the next request is taken but
//   completes only once the output register frees up.

module linked_fifo_with_thread_free_lists_core #(
  parameter int POOL_NODES = lfq_pkg::POOL_NODES_DEF,
  parameter int THREADS    = lfq_pkg::THREADS_DEF,
  parameter int DATA_WIDTH = lfq_pkg::DATA_WIDTH_DEF,
  localparam int PW = $clog2(POOL_NODES + 1),
  localparam int AW = $clog2(POOL_NODES),
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [TW-1:0]         in_thread_id,
  input  logic [DATA_WIDTH-1:0] in_data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic [DATA_WIDTH-1:0] out_data_out,
  output logic                  out_recycled,
  output logic [PW-1:0]         out_free_count
);

  localparam logic [PW-1:0] NULL_IDX = PW'(POOL_NODES);

  lfq_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt;

  // latched request
  logic                  op_mode_r;
  logic [TW-1:0]         op_tid_r;
  logic                  op_tid_ok_r;
  logic [DATA_WIDTH-1:0] op_data_r;
  logic [PW-1:0]         op_fh_r;
  logic [PW-1:0]         op_fs_r;

  logic                  out_valid_r;
  logic                  out_ok_r, out_ok_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                  out_recycled_r, out_recycled_nxt;
  logic [PW-1:0]         out_count_r, out_count_nxt;

  logic accept, done;

  logic [PW-1:0]         fl_head, fl_size;
  lfq_pkg::fl_cmd_t      fl_cmd;
  logic [PW-1:0]         fl_new_head;

  logic [PW-1:0]         rd_link;
  logic [DATA_WIDTH-1:0] rd_value;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PW-1:0]         wr_link;
  logic [DATA_WIDTH-1:0] wr_value;
  logic [AW-1:0]         rd_addr;

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfq_pkg::ST_IDLE: if (in_valid) state_nxt = lfq_pkg::ST_EXEC;
      lfq_pkg::ST_EXEC: if (!out_valid_r || out_ready) state_nxt = lfq_pkg::ST_IDLE;
      default:          state_nxt = lfq_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    unique case (state_r)
      lfq_pkg::ST_IDLE: in_ready = 1'b1;
      lfq_pkg::ST_EXEC: done     = !out_valid_r || out_ready;
      default:          in_ready = 1'b0;
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign rd_addr = (in_mode == lfq_pkg::MODE_ENQ) ? fl_head[AW-1:0] : head_r[AW-1:0];

  // execute cycle: read data from the node RAM is valid here
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    fresh_nxt        = fresh_r;
    fl_cmd           = '0;
    fl_new_head      = op_fh_r;
    wr_en            = 1'b0;
    wr_addr          = tail_r[AW-1:0];
    wr_link          = NULL_IDX;
    wr_value         = op_data_r;
    out_ok_nxt       = 1'b0;
    out_data_nxt     = '0;
    out_recycled_nxt = 1'b0;
    out_count_nxt    = '0;
    if (op_tid_ok_r) begin
      out_count_nxt = op_fs_r;
      if (op_mode_r == lfq_pkg::MODE_ENQ) begin
        priority if (op_fh_r != NULL_IDX) begin
          fl_cmd.pop    = done;
          fl_new_head   = rd_link;
          out_count_nxt = op_fs_r - PW'(1);
          wr_en         = done;
          wr_link       = op_fh_r;
          tail_nxt      = op_fh_r;
          out_ok_nxt    = 1'b1;
        end else if (fresh_r != NULL_IDX) begin
          fresh_nxt     = fresh_r + PW'(1);
          wr_en         = done;
          wr_link       = fresh_r;
          tail_nxt      = fresh_r;
          out_ok_nxt    = 1'b1;
        end else begin
          out_ok_nxt    = 1'b0;
        end
      end else if (head_r != tail_r) begin
        // old dummy goes onto the caller's free list
        head_nxt         = rd_link;
        out_data_nxt     = rd_value;
        wr_en            = done;
        wr_addr          = head_r[AW-1:0];
        wr_link          = op_fh_r;
        fl_cmd.push      = done;
        fl_new_head      = head_r;
        out_count_nxt    = op_fs_r + PW'(1);
        out_ok_nxt       = 1'b1;
        out_recycled_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fresh_r     <= PW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        fresh_r     <= fresh_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode_r   <= in_mode;
      op_tid_r    <= in_thread_id;
      op_tid_ok_r <= (32'(in_thread_id) < THREADS);
      op_data_r   <= in_data_in;
      op_fh_r     <= fl_head;
      op_fs_r     <= fl_size;
    end
    if (done) begin
      out_ok_r       <= out_ok_nxt;
      out_data_r     <= out_data_nxt;
      out_recycled_r <= out_recycled_nxt;
      out_count_r    <= out_count_nxt;
    end
  end

  lfq_free_lists #(
    .POOL_NODES (POOL_NODES),
    .THREADS    (THREADS)
  ) u_free_lists (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_tid   (in_thread_id),
    .rd_head  (fl_head),
    .rd_size  (fl_size),
    .cmd      (fl_cmd),
    .cmd_tid  (op_tid_r),
    .cmd_head (fl_new_head)
  );

  lfq_node_ram #(
    .POOL_NODES (POOL_NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_node_ram (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_link  (rd_link),
    .rd_value (rd_value),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_link  (wr_link),
    .wr_value (wr_value)
  );

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_data_out   = out_data_r;
  assign out_recycled   = out_recycled_r;
  assign out_free_count = out_count_r;

endmodule

### rtl/core/lfq_node_ram.sv
// Node pool memory: one word per node holding {link, value}, registered read.
`timescale 1ns / 1ps

module lfq_node_ram #(
  parameter int POOL_NODES = lfq_pkg::POOL_NODES_DEF,
  parameter int DATA_WIDTH = lfq_pkg::DATA_WIDTH_DEF,
  localparam int PW = $clog2(POOL_NODES + 1),
  localparam int AW = $clog2(POOL_NODES)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [PW-1:0]         rd_link,
  output logic [DATA_WIDTH-1:0] rd_value,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [PW-1:0]         wr_link,
  input  logic [DATA_WIDTH-1:0] wr_value
);

  logic [PW+DATA_WIDTH-1:0] mem_r [POOL_NODES];
  logic [PW+DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_link, wr_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_link  = rd_data_r[PW+DATA_WIDTH-1:DATA_WIDTH];
  assign rd_value = rd_data_r[DATA_WIDTH-1:0];

endmodule

### rtl/core/lfq_free_lists.sv
// Per-thread free list heads and sizes.
`timescale 1ns / 1ps

module lfq_free_lists #(
  parameter int POOL_NODES = lfq_pkg::POOL_NODES_DEF,
  parameter int THREADS    = lfq_pkg::THREADS_DEF,
  localparam int PW = $clog2(POOL_NODES + 1),
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TW-1:0]    rd_tid,
  output logic [PW-1:0]    rd_head,
  output logic [PW-1:0]    rd_size,
  input  lfq_pkg::fl_cmd_t cmd,
  input  logic [TW-1:0]    cmd_tid,
  input  logic [PW-1:0]    cmd_head
);

  logic [PW-1:0] head_r [THREADS];
  logic [PW-1:0] size_r [THREADS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < THREADS; t++) begin
        head_r[t] <= PW'(POOL_NODES);
        size_r[t] <= '0;
      end
    end else if (cmd.pop) begin
      head_r[cmd_tid] <= cmd_head;
      size_r[cmd_tid] <= size_r[cmd_tid] - PW'(1);
    end else if (cmd.push) begin
      head_r[cmd_tid] <= cmd_head;
      size_r[cmd_tid] <= size_r[cmd_tid] + PW'(1);
    end
  end

  assign rd_head = head_r[rd_tid];
  assign rd_size = size_r[rd_tid];

endmodule
